// ----- rtl/mob_pkg.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot orbit minimum: shared package
// Widths, register indexes, reset values and sequencer state types that are
// used by the channel interfaces and by the modules of the block.
// ----------------------------------------------------------------------------
package mob_pkg;

    // Default number of fraction bits of every fixed-point value.
    localparam int DEF_FRAC_BITS = 28;

    // Fixed widths of the channel fields.
    localparam int C_W        = 32;
    localparam int ITER_W     = 16;
    localparam int SCALE_W    = 10;
    localparam int MSAT_W     = 31;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BAND_SCALE = CFG_IDX_W'(1);

    // Register values after reset.
    localparam logic [ITER_W-1:0]  RST_MAX_ITER   = ITER_W'(1000);
    localparam logic [SCALE_W-1:0] RST_BAND_SCALE = SCALE_W'(100);

    // Largest value of the saturated orbit minimum.
    localparam logic [MSAT_W-1:0] MSAT_MAX = {MSAT_W{1'b1}};

    // Main sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RR,
        S_RR_W,
        S_II,
        S_II_W,
        S_NORM,
        S_CHECK,
        S_RI,
        S_RI_W,
        S_BAND,
        S_BAND_W
    } t_state;

    // Phases of the shared multiplier.
    typedef enum logic [2:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_ACC,
        MP_FIN
    } t_mul_phase;

    // Phases of the zebra band unit.
    typedef enum logic [2:0] {
        BP_IDLE,
        BP_SQ,
        BP_MUL,
        BP_PREP,
        BP_ROOT
    } t_band_phase;

    // Command from the sequencer to the shared multiplier.
    typedef struct packed {
        logic start;
        logic neg;
        logic dbl;
    } t_mul_ctl;

endpackage

// ----- rtl/mob_if.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot orbit minimum: channel interfaces
// Valid/ready channels for the input point, the result and the register
// writes. A beat moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------

// Input point c.
interface mob_pt_if import mob_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic signed [C_W-1:0] c_re;
    logic signed [C_W-1:0] c_im;

    modport source (output valid, output c_re, output c_im, input ready);
    modport sink   (input valid, input c_re, input c_im, output ready);
endinterface

// Result of one point.
interface mob_res_if import mob_pkg::*;;
    logic              valid;
    logic              ready;
    logic              escaped;
    logic [ITER_W-1:0] iter_count;
    logic [MSAT_W-1:0] min_norm_sq;
    logic              zebra_white;

    modport source (output valid, output escaped, output iter_count,
                    output min_norm_sq, output zebra_white, input ready);
    modport sink   (input valid, input escaped, input iter_count,
                    input min_norm_sq, input zebra_white, output ready);
endinterface

// Register write channel.
interface mob_cfg_if import mob_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/mob_mul.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot orbit minimum: shared multiplier
// Multiplies two magnitudes in two half-width passes, optionally doubles the
// product, applies the sign and floors the result by 2^FRAC_BITS.
// ----------------------------------------------------------------------------
module mob_mul import mob_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int ZW = FRAC_BITS + 8,
    localparam int LW = (ZW + 1) / 2,
    localparam int PW = 2 * ZW,
    localparam int QW = PW - FRAC_BITS,
    localparam int RW = QW + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mul_ctl             i_ctl,
    input  logic [ZW-1:0]        i_a,
    input  logic [ZW-1:0]        i_b,
    output logic                 o_done,
    output logic signed [RW-1:0] o_res
);

    t_mul_phase r_phase, n_phase;
    logic                 r_done;
    logic [ZW-1:0]        r_a;
    logic [ZW-1:0]        r_b;
    logic                 r_neg;
    logic                 r_dbl;
    logic [ZW+LW-1:0]     r_pp;
    logic [PW-1:0]        r_acc;
    logic signed [RW-1:0] r_res;

    logic [LW-1:0]        b_lo;
    logic [LW-1:0]        b_hi;
    logic [ZW+LW-1:0]     limb_prod;
    logic [PW-1:0]        acc_dbl;
    logic [QW-1:0]        quot;
    logic                 rem_nz;
    logic signed [RW-1:0] floor_res;

    // Limb selection and the one multiplier of the unit.
    assign b_lo      = r_b[LW-1:0];
    assign b_hi      = LW'(r_b >> LW);
    assign limb_prod = (ZW+LW)'(r_a) * (ZW+LW)'((r_phase == MP_LO) ? b_lo : b_hi);

    // Doubling, truncation toward minus infinity and sign.
    assign acc_dbl   = r_dbl ? (r_acc << 1) : r_acc;
    assign quot      = QW'(acc_dbl >> FRAC_BITS);
    assign rem_nz    = |acc_dbl[FRAC_BITS-1:0];
    assign floor_res = r_neg ? -($signed(RW'(quot)) + $signed(RW'(rem_nz)))
                             : $signed(RW'(quot));

    // Phase sequence.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            MP_IDLE: begin
                if (i_ctl.start) begin
                    n_phase = MP_LO;
                end
            end
            MP_LO:   n_phase = MP_HI;
            MP_HI:   n_phase = MP_ACC;
            MP_ACC:  n_phase = MP_FIN;
            MP_FIN:  n_phase = MP_IDLE;
            default: n_phase = MP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == MP_FIN);
        end
    end

    // Operand latch, partial products and accumulation.
    always_ff @(posedge i_clk) begin
        case (r_phase)
            MP_IDLE: begin
                if (i_ctl.start) begin
                    r_a   <= i_a;
                    r_b   <= i_b;
                    r_neg <= i_ctl.neg;
                    r_dbl <= i_ctl.dbl;
                end
            end
            MP_LO: begin
                r_pp <= limb_prod;
            end
            MP_HI: begin
                r_acc <= PW'(r_pp);
                r_pp  <= limb_prod;
            end
            MP_ACC: begin
                r_acc <= r_acc + (PW'(r_pp) << LW);
            end
            MP_FIN: begin
                r_res <= floor_res;
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- rtl/mob_band.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot orbit minimum: zebra band unit
// Scales the orbit minimum by band_scale squared, drops the fraction bits and
// takes the integer square root one result bit per cycle; reports its parity.
// ----------------------------------------------------------------------------
module mob_band import mob_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MSAT_W-1:0]  i_msat,
    input  logic [SCALE_W-1:0] i_scale,
    output logic               o_done,
    output logic               o_white
);

    localparam int PRW = MSAT_W + 2 * SCALE_W;
    localparam int SCW = PRW - FRAC_BITS;
    localparam int RB  = (SCW + 1) / 2;
    localparam int XW  = 2 * RB;
    localparam int CW  = $clog2(RB);

    t_band_phase r_phase, n_phase;
    logic                 r_done;
    logic [MSAT_W-1:0]    r_msat;
    logic [SCALE_W-1:0]   r_scale;
    logic [2*SCALE_W-1:0] r_s2;
    logic [PRW-1:0]       r_prod;
    logic [XW-1:0]        r_x;
    logic [RB+1:0]        r_rem;
    logic [RB-1:0]        r_root;
    logic [CW-1:0]        r_cnt;

    logic [RB+3:0]        rem_sh;
    logic [RB+3:0]        trial;
    logic                 fits;

    // One restoring square root step.
    assign rem_sh = {r_rem, r_x[XW-1:XW-2]};
    assign trial  = (RB+4)'({r_root, 2'b01});
    assign fits   = (rem_sh >= trial);

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            BP_IDLE: begin
                if (i_start) begin
                    n_phase = BP_SQ;
                end
            end
            BP_SQ:   n_phase = BP_MUL;
            BP_MUL:  n_phase = BP_PREP;
            BP_PREP: n_phase = BP_ROOT;
            BP_ROOT: begin
                if (r_cnt == '0) begin
                    n_phase = BP_IDLE;
                end
            end
            default: n_phase = BP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= BP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (r_phase == BP_IDLE && i_start) begin
                r_done <= 1'b0;
            end else if (r_phase == BP_ROOT && r_cnt == '0) begin
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: square the scale, scale the minimum, then the root bits.
    always_ff @(posedge i_clk) begin
        case (r_phase)
            BP_IDLE: begin
                if (i_start) begin
                    r_msat  <= i_msat;
                    r_scale <= i_scale;
                end
            end
            BP_SQ: begin
                r_s2 <= (2*SCALE_W)'(r_scale) * (2*SCALE_W)'(r_scale);
            end
            BP_MUL: begin
                r_prod <= PRW'(r_msat) * PRW'(r_s2);
            end
            BP_PREP: begin
                r_x    <= XW'(r_prod >> FRAC_BITS);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(RB - 1);
            end
            BP_ROOT: begin
                r_x   <= r_x << 2;
                r_cnt <= r_cnt - 1'b1;
                if (fits) begin
                    r_rem  <= (RB+2)'(rem_sh - trial);
                    r_root <= {r_root[RB-2:0], 1'b1};
                end else begin
                    r_rem  <= (RB+2)'(rem_sh);
                    r_root <= {r_root[RB-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done  = r_done;
    assign o_white = ~r_root[0];

endmodule

// ----- rtl/mandelbrot_orbit_minimum_top.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot orbit minimum: top level
// Escape-time iteration of z = z*z + c with an orbit trap on |z|^2, built on
// one shared multiplier under a small sequencer, plus the zebra band unit.
// ----------------------------------------------------------------------------
// One point is worked on at a time; the input is ready only while the block
// is idle. Every product runs through the one shared multiplier in two
// half-width passes. The start forms the squares of c and does the first
// norm check, each further iteration forms the doubled cross product, both
// squares, the norm and the check, and the final band step takes the
// bit-serial square root. The finished result sits in an output register,
// so the next point can be accepted while the result still waits to be
// taken. Register writes are always accepted and take effect at once, so
// they belong between points.
// ----------------------------------------------------------------------------
module mandelbrot_orbit_minimum_top import mob_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mob_pt_if.sink     i_pt,
    mob_cfg_if.sink    i_cfg,
    mob_res_if.source  o_res
);

    localparam int ZW = FRAC_BITS + 8;
    localparam int PW = 2 * ZW;
    localparam int QW = PW - FRAC_BITS;
    localparam int RW = QW + 1;
    localparam int NW = QW + 1;
    localparam int XW = QW + 2;

    localparam logic [NW-1:0] FOUR = NW'(4) << FRAC_BITS;
    localparam logic signed [XW-1:0] ZMAX = $signed({{(XW-ZW+1){1'b0}}, {(ZW-1){1'b1}}});
    localparam logic signed [XW-1:0] ZMIN = $signed({{(XW-ZW+1){1'b1}}, {(ZW-1){1'b0}}});

    // Clamp a wide signed value into the range of a z component.
    function automatic logic signed [ZW-1:0] sat_z(input logic signed [XW-1:0] v);
        logic signed [ZW-1:0] r;
        if (v > ZMAX) begin
            r = ZMAX[ZW-1:0];
        end else if (v < ZMIN) begin
            r = ZMIN[ZW-1:0];
        end else begin
            r = v[ZW-1:0];
        end
        return r;
    endfunction

    t_state r_state, n_state;

    logic [ITER_W-1:0]    r_max_iter;
    logic [SCALE_W-1:0]   r_band_scale;
    logic signed [ZW-1:0] r_cr;
    logic signed [ZW-1:0] r_ci;
    logic signed [ZW-1:0] r_zr;
    logic signed [ZW-1:0] r_zi;
    logic signed [RW-1:0] r_rr;
    logic signed [RW-1:0] r_ii;
    logic [NW-1:0]        r_norm;
    logic [NW-1:0]        r_min;
    logic [ITER_W-1:0]    r_iter;

    logic                 r_ov;
    logic                 r_o_esc;
    logic [ITER_W-1:0]    r_o_time;
    logic [MSAT_W-1:0]    r_o_min;
    logic                 r_o_white;

    t_mul_ctl             mul_ctl;
    logic [ZW-1:0]        mul_a;
    logic [ZW-1:0]        mul_b;
    logic                 mul_done;
    logic signed [RW-1:0] mul_res;
    logic                 band_start;
    logic                 band_done;
    logic                 band_white;

    logic [ZW-1:0]        zr_mag;
    logic [ZW-1:0]        zi_mag;
    logic [NW-1:0]        norm_sum;
    logic [MSAT_W-1:0]    msat;
    logic                 out_free;
    logic                 out_load;
    logic                 pt_take;
    logic signed [ZW-1:0] c_re_sat;
    logic signed [ZW-1:0] c_im_sat;

    // Magnitudes of z, norm and saturated minimum.
    assign zr_mag   = r_zr[ZW-1] ? (~r_zr + 1'b1) : r_zr;
    assign zi_mag   = r_zi[ZW-1] ? (~r_zi + 1'b1) : r_zi;
    assign norm_sum = NW'(r_rr[QW-1:0]) + NW'(r_ii[QW-1:0]);
    assign msat     = (r_min > NW'(MSAT_MAX)) ? MSAT_MAX : r_min[MSAT_W-1:0];
    assign c_re_sat = sat_z(XW'(i_pt.c_re));
    assign c_im_sat = sat_z(XW'(i_pt.c_im));

    assign out_free = ~r_ov | o_res.ready;
    assign pt_take  = i_pt.valid & i_pt.ready;

    // Shared multiplier.
    mob_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // Zebra band unit.
    mob_band #(.FRAC_BITS(FRAC_BITS)) u_band (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (band_start),
        .i_msat  (msat),
        .i_scale (r_band_scale),
        .o_done  (band_done),
        .o_white (band_white)
    );

    // Sequencer: next state, multiplier commands and handshakes.
    always_comb begin
        n_state       = r_state;
        mul_ctl.start = 1'b0;
        mul_ctl.neg   = 1'b0;
        mul_ctl.dbl   = 1'b0;
        mul_a         = zr_mag;
        mul_b         = zr_mag;
        band_start    = 1'b0;
        out_load      = 1'b0;
        i_pt.ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_pt.ready = 1'b1;
                if (i_pt.valid) begin
                    n_state = S_RR;
                end
            end
            S_RR: begin
                mul_ctl.start = 1'b1;
                n_state       = S_RR_W;
            end
            S_RR_W: begin
                if (mul_done) begin
                    n_state = S_II;
                end
            end
            S_II: begin
                mul_ctl.start = 1'b1;
                mul_a         = zi_mag;
                mul_b         = zi_mag;
                n_state       = S_II_W;
            end
            S_II_W: begin
                if (mul_done) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_iter < r_max_iter && r_norm < FOUR) begin
                    n_state = S_RI;
                end else begin
                    n_state = S_BAND;
                end
            end
            S_RI: begin
                mul_ctl.start = 1'b1;
                mul_ctl.neg   = r_zr[ZW-1] ^ r_zi[ZW-1];
                mul_ctl.dbl   = 1'b1;
                mul_b         = zi_mag;
                n_state       = S_RI_W;
            end
            S_RI_W: begin
                if (mul_done) begin
                    n_state = S_RR;
                end
            end
            S_BAND: begin
                band_start = 1'b1;
                n_state    = S_BAND_W;
            end
            S_BAND_W: begin
                if (band_done && out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state: sequencer, registers and output beat flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max_iter   <= RST_MAX_ITER;
            r_band_scale <= RST_BAND_SCALE;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_MAX_ITER:   r_max_iter   <= i_cfg.data[ITER_W-1:0];
                    REG_BAND_SCALE: r_band_scale <= i_cfg.data[SCALE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign i_cfg.ready = 1'b1;

    // Orbit datapath.
    always_ff @(posedge i_clk) begin
        if (pt_take) begin
            r_cr   <= c_re_sat;
            r_ci   <= c_im_sat;
            r_zr   <= c_re_sat;
            r_zi   <= c_im_sat;
            r_iter <= ITER_W'(1);
        end
        if (r_state == S_RR_W && mul_done) begin
            r_rr <= mul_res;
        end
        if (r_state == S_II_W && mul_done) begin
            r_ii <= mul_res;
        end
        if (r_state == S_NORM) begin
            r_norm <= norm_sum;
            if (r_iter == ITER_W'(1) || norm_sum < r_min) begin
                r_min <= norm_sum;
            end
        end
        if (r_state == S_RI_W && mul_done) begin
            r_zr   <= sat_z(XW'(r_rr) - XW'(r_ii) + XW'(r_cr));
            r_zi   <= sat_z(XW'(mul_res) + XW'(r_ci));
            r_iter <= r_iter + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_esc   <= (r_norm > FOUR);
            r_o_time  <= r_iter;
            r_o_min   <= msat;
            r_o_white <= band_white;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.escaped     = r_o_esc;
    assign o_res.iter_count  = r_o_time;
    assign o_res.min_norm_sq = r_o_min;
    assign o_res.zebra_white = r_o_white;

`ifndef SYNTH
    // The multiplier only finishes while the sequencer waits for it.
    a_mul_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_RR_W || r_state == S_II_W || r_state == S_RI_W))
        else $error("multiplier finished outside a wait state");

    // The loop only stops on the iteration limit or a norm of four or more.
    a_stop_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BAND) |-> (r_iter >= r_max_iter || r_norm >= FOUR))
        else $error("orbit loop stopped early");

    // The tracked minimum never exceeds the current norm.
    a_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_min <= r_norm))
        else $error("orbit minimum above current norm");

    // The band result appears only while the sequencer waits for it.
    a_band_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(band_done) |-> (r_state == S_BAND_W))
        else $error("band unit finished outside its wait state");
`endif

endmodule
